// ===== sv/bf3_pkg.sv =====
// Package: types, constants and weight tables of the 3x3 bilateral filter.
`default_nettype none
package bf3_pkg;

   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int DEF_WEIGHT_BITS = 16;
   localparam int DIAMETER        = 3;
   localparam int MAX_HEIGHT      = 4095;
   localparam int MIN_DIM         = 3;
   localparam int QUOT_BITS       = 16;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 12;
   localparam int CSR_DATA_BITS   = 12;
   localparam logic [63:0] EXP_Q32 = 64'd4280080076;

   localparam logic [WIDTH_REG_BITS-1:0]  RESET_WIDTH  = 11'd640;
   localparam logic [HEIGHT_REG_BITS-1:0] RESET_HEIGHT = 12'd480;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [15:0] filtered_value;
      logic [11:0] row;
      logic [9:0]  column;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef logic [63:0] range_tab_type [256];

   function automatic logic [63:0] rnd_shift(logic [63:0] v, int s);
      logic [63:0] r;
      if (s == 0) begin
         r = v;
      end else begin
         r = (v + (64'd1 << (s - 1))) >> s;
      end
      return r;
   endfunction

   function automatic range_tab_type build_range(int wb);
      range_tab_type t;
      logic [63:0]   g;
      logic [63:0]   p;
      g = 64'd1 << 32;
      p = EXP_Q32;
      for (int d = 0; d < 256; d++) begin
         t[d] = rnd_shift(g, 32 - wb);
         g = rnd_shift(g * p, 32);
         p = rnd_shift(rnd_shift(p * EXP_Q32, 32) * EXP_Q32, 32);
      end
      return t;
   endfunction

   function automatic logic [63:0] space_weight(logic [1:0] dist2, int wb);
      logic [63:0] s;
      case (dist2)
         2'd0:    s = 64'd16777216;
         2'd1:    s = 64'd16744480;
         default: s = 64'd16711808;
      endcase
      return rnd_shift(s, 24 - wb);
   endfunction

endpackage
`default_nettype wire

// ===== sv/bf3_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bf3_div #(
   parameter int DVD_W = 38,
   parameter int DEN_W = 21
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [DVD_W-1:0]                 dividend,
   input  wire logic [DEN_W-1:0]                 divisor,
   output logic                                  done,
   output logic [bf3_pkg::QUOT_BITS-1:0]         quotient
);
   localparam int QB    = bf3_pkg::QUOT_BITS;
   localparam int REM_W = DEN_W + 1;
   localparam int CNT_W = $clog2(QB + 1);

   logic [REM_W-1:0] rem_ff, rem_in, trial;
   logic [QB-1:0]    quo_ff, quo_in;
   logic [QB-1:0]    low_ff, low_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[REM_W-2:0], low_ff[QB-1]};
      if (start) begin
         rem_in  = REM_W'(dividend >> QB);
         low_in  = dividend[QB-1:0];
         quo_in  = '0;
         cnt_in  = CNT_W'(QB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QB-2:0], 1'b0};
         end
         low_in = {low_ff[QB-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      low_ff <= low_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < {1'b0, den_ff})
      else $error("divider remainder not below divisor");
   a_den_nz: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> den_ff != '0)
      else $error("divider divisor zero");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with zero count");
endmodule
`default_nettype wire

// ===== sv/bilateral_filter_3x3_top.sv =====
// Top level of the streaming 3x3 bilateral filter for 8-bit grayscale pixels.
// Steps per pixel: line read, then a multiply and an accumulate state for each of the nine
// window taps, divider load, restoring divide and output; border pixels give no result.
// A new pixel is accepted only once the previous one is done, and a held result waiting
// for rsp_ready stalls the filter; pace is set by the serial weight unit and divider.
// Reset: counters and window cleared, sizes 640 x 480; line memory not cleared.
`default_nettype none
module bilateral_filter_3x3_top #(
   parameter int MAX_WIDTH   = bf3_pkg::DEF_MAX_WIDTH,
   parameter int WEIGHT_BITS = bf3_pkg::DEF_WEIGHT_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire bf3_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output bf3_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_we,
   input  wire logic                               csr_index,
   input  wire logic [bf3_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   localparam int WB    = WEIGHT_BITS;
   localparam int R_W   = WB + 1;
   localparam int P_W   = 2 * R_W;
   localparam int NUM_W = R_W + 8 + 4;
   localparam int DEN_W = R_W + 4;
   localparam int DVD_W = NUM_W + 9;
   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW_W  = $clog2(MAX_WIDTH + 1);
   localparam int CW_W  = (EW_W > bf3_pkg::WIDTH_REG_BITS) ? EW_W : bf3_pkg::WIDTH_REG_BITS;
   localparam int HB    = bf3_pkg::HEIGHT_REG_BITS;
   localparam bf3_pkg::range_tab_type RANGE_TAB = bf3_pkg::build_range(WEIGHT_BITS);

   bf3_pkg::state_type state_ff, state_in;

   logic [bf3_pkg::WIDTH_REG_BITS-1:0] img_w_ff;
   logic [HB-1:0]                      img_h_ff;
   logic [CW_W-1:0] ew;
   logic [HB-1:0]   eh;

   logic [COL_W-1:0] col_ff;
   logic [HB-1:0]    row_ff;
   logic [7:0]       px_ff;
   logic [15:0]      line_mem [MAX_WIDTH];
   logic [15:0]      rd_ff;
   logic [7:0]       win_ff [3][3];

   logic [1:0]       tap_r_ff, tap_c_ff;
   logic [P_W-1:0]   prod_ff;
   logic [7:0]       tap_v_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [HB-1:0]    cr_ff;
   logic [COL_W-1:0] cc_ff;
   logic             last_ff;
   logic             rsp_valid_ff;
   bf3_pkg::rsp_type rsp_ff;

   logic             accept, emit, rsp_load, div_start, div_done, last_tap, do_read;
   logic [COL_W:0]   col_next;
   logic [HB-1:0]    row_next;
   logic [7:0]       tap_v, ctr, diff;
   logic [R_W-1:0]   r_val, s_val;
   logic [1:0]       dist2;
   logic [P_W-1:0]   wt_full;
   logic [R_W-1:0]   wt;
   logic [DVD_W-1:0] dividend;
   logic [bf3_pkg::QUOT_BITS-1:0] quotient;

   // effective frame size
   always_comb begin
      if (CW_W'(img_w_ff) < CW_W'(bf3_pkg::MIN_DIM)) begin
         ew = CW_W'(bf3_pkg::MIN_DIM);
      end else if (CW_W'(img_w_ff) > CW_W'(MAX_WIDTH)) begin
         ew = CW_W'(MAX_WIDTH);
      end else begin
         ew = CW_W'(img_w_ff);
      end
      if (img_h_ff < HB'(bf3_pkg::MIN_DIM)) begin
         eh = HB'(bf3_pkg::MIN_DIM);
      end else if (img_h_ff > HB'(bf3_pkg::MAX_HEIGHT)) begin
         eh = HB'(bf3_pkg::MAX_HEIGHT);
      end else begin
         eh = img_h_ff;
      end
   end

   assign accept   = req_valid && req_ready;
   assign emit     = (row_ff >= HB'(2)) && (col_ff >= COL_W'(2));
   assign col_next = {1'b0, col_ff} + (COL_W + 1)'(1);
   assign row_next = row_ff + HB'(1);
   assign last_tap = (tap_r_ff == 2'd2) && (tap_c_ff == 2'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bf3_pkg::ST_IDLE: if (accept) state_in = bf3_pkg::ST_READ;
         bf3_pkg::ST_READ: state_in = emit ? bf3_pkg::ST_MUL : bf3_pkg::ST_IDLE;
         bf3_pkg::ST_MUL:  state_in = bf3_pkg::ST_ACC;
         bf3_pkg::ST_ACC:  state_in = last_tap ? bf3_pkg::ST_LOAD : bf3_pkg::ST_MUL;
         bf3_pkg::ST_LOAD: state_in = bf3_pkg::ST_DIV;
         bf3_pkg::ST_DIV:  if (div_done) state_in = bf3_pkg::ST_OUT;
         bf3_pkg::ST_OUT:  if (!rsp_valid_ff || rsp_ready) state_in = bf3_pkg::ST_IDLE;
         default:          state_in = bf3_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      do_read   = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         bf3_pkg::ST_IDLE: req_ready = 1'b1;
         bf3_pkg::ST_READ: do_read   = 1'b1;
         bf3_pkg::ST_LOAD: div_start = 1'b1;
         bf3_pkg::ST_OUT:  rsp_load  = !rsp_valid_ff || rsp_ready;
         default:          req_ready = 1'b0;
      endcase
   end

   // weight of current tap
   always_comb begin
      tap_v   = win_ff[tap_r_ff][tap_c_ff];
      ctr     = win_ff[1][1];
      diff    = (tap_v >= ctr) ? tap_v - ctr : ctr - tap_v;
      r_val   = RANGE_TAB[diff][R_W-1:0];
      dist2   = {1'b0, tap_r_ff != 2'd1} + {1'b0, tap_c_ff != 2'd1};
      s_val   = R_W'(bf3_pkg::space_weight(dist2, WEIGHT_BITS));
      wt_full = (prod_ff + (P_W'(1) << (WB - 1))) >> WB;
      wt      = wt_full[R_W-1:0];
   end

   assign dividend = {num_ff, 8'd0} + DVD_W'(den_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bf3_pkg::ST_IDLE;
         img_w_ff     <= bf3_pkg::RESET_WIDTH;
         img_h_ff     <= bf3_pkg::RESET_HEIGHT;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_index == bf3_pkg::CSR_IMAGE_WIDTH) begin
               img_w_ff <= csr_wdata[bf3_pkg::WIDTH_REG_BITS-1:0];
            end else begin
               img_h_ff <= csr_wdata[HB-1:0];
            end
         end
         if (accept && req_data.frame_start) begin
            col_ff <= '0;
            row_ff <= '0;
         end
         if (do_read) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= rd_ff[15:8];
            win_ff[1][2] <= rd_ff[7:0];
            win_ff[2][2] <= px_ff;
            if (CW_W'(col_next) >= ew) begin
               col_ff <= '0;
               if (row_next >= eh) begin
                  row_ff <= '0;
               end else begin
                  row_ff <= row_next;
               end
            end else begin
               col_ff <= col_next[COL_W-1:0];
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // line memory: entry holds {older line, newer line}
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[req_data.frame_start ? COL_W'(0) : col_ff];
      end
      if (do_read) begin
         line_mem[col_ff] <= {rd_ff[7:0], px_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= req_data.pixel;
      end
      if (do_read) begin
         cr_ff    <= row_ff - HB'(1);
         cc_ff    <= col_ff - COL_W'(1);
         last_ff  <= (row_ff - HB'(1) == eh - HB'(2)) &&
                     (CW_W'(col_ff - COL_W'(1)) == ew - CW_W'(2));
         tap_r_ff <= 2'd0;
         tap_c_ff <= 2'd0;
         num_ff   <= '0;
         den_ff   <= '0;
      end
      if (state_ff == bf3_pkg::ST_MUL) begin
         prod_ff  <= P_W'(r_val) * P_W'(s_val);
         tap_v_ff <= tap_v;
      end
      if (state_ff == bf3_pkg::ST_ACC) begin
         num_ff <= num_ff + NUM_W'(wt) * NUM_W'(tap_v_ff);
         den_ff <= den_ff + DEN_W'(wt);
         if (tap_c_ff == 2'd2) begin
            tap_c_ff <= 2'd0;
            tap_r_ff <= tap_r_ff + 2'd1;
         end else begin
            tap_c_ff <= tap_c_ff + 2'd1;
         end
      end
      if (rsp_load) begin
         rsp_ff.filtered_value <= quotient;
         rsp_ff.row            <= cr_ff;
         rsp_ff.column         <= 10'(cc_ff);
         rsp_ff.last           <= last_ff;
      end
   end

   bf3_div #(
      .DVD_W(DVD_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == bf3_pkg::ST_IDLE)
      else $error("ready outside idle");
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bf3_pkg::ST_MUL) |-> (tap_r_ff != 2'd3 && tap_c_ff != 2'd3))
      else $error("tap index out of range");
   a_den_nz: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bf3_pkg::ST_LOAD) |-> den_ff != '0)
      else $error("weight sum zero at divide");
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == bf3_pkg::ST_DIV)
      else $error("divider done outside divide state");
endmodule
`default_nettype wire
